### rtl/lst_pkg.sv
// Shared types and constants for the light selection top-k block.
// Used by every module under rtl/ except lst_queue; depends on nothing.
package lst_pkg;

	localparam int MAX_OUT_DEF     = 4;
	localparam int MAX_SCORED_DEF  = 32;
	localparam int LIGHT_SLOTS_DEF = 256;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIGHTS = 3'd4;

	localparam logic [1:0] TYPE_DIRECTIONAL = 2'd0;
	localparam logic [1:0] TYPE_POINT       = 2'd1;

	typedef enum logic [1:0] {
		KIND_SKIP,
		KIND_DIR,
		KIND_POINT
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] light_range;
		logic [31:0] inv_range_sq;
		logic [15:0] intensity;
		logic        last_light;
	} item_t;

	// 2^48 - 2^32: largest distSq * inv_range_sq that gives nonzero attenuation
	localparam logic [79:0] ATTEN_LIMIT = 80'h0000_0000_FFFF_0000_0000;
	localparam logic [48:0] DEN_BASE    = 49'h0_0001_0000_0000;
	localparam logic [48:0] REM_INIT    = 49'h0_0000_8000_0000;
	localparam logic [16:0] ATTEN_ONE   = 17'h10000;

endpackage

### rtl/light_select_top_k_core.sv
// Top level of the per-object light selection block: config registers,
// front, queue and back. Depends on lst_pkg, lst_front, lst_queue, lst_back.
//
// Lights enter one word per push, numbered from 0 within each set. A
// directional or ignored light needs no arithmetic in the back end; a point
// light uses the shared 32x32 multiplier (squares, cull bound, attenuation
// product, score) and, with positive range, the one-bit-per-cycle
// attenuation divider (17 steps). A two-word queue
// lets the front keep accepting while the back works. After the last light,
// results leave one per cycle while pop is held, through a single output register.
module light_select_top_k_core #(
	parameter int MAX_OUT     = lst_pkg::MAX_OUT_DEF,
	parameter int MAX_SCORED  = lst_pkg::MAX_SCORED_DEF,
	parameter int LIGHT_SLOTS = lst_pkg::LIGHT_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    light_type,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic signed [31:0]            pos_z,
	input  logic signed [31:0]            light_range,
	input  logic [31:0]                   inv_range_sq,
	input  logic [15:0]                   intensity,
	input  logic                          last_light,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    light_index,
	output logic [1:0]                    out_slot,
	output logic                          none_selected,
	output logic                          last_result
);

	localparam int IDX_W = $clog2(LIGHT_SLOTS);
	localparam int QW    = IDX_W + $bits(lst_pkg::item_t);

	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic [30:0]        radius_q;
	logic [2:0]         max_lights_q;
	logic               q_full, q_empty, q_push, q_pop;
	logic [QW-1:0]      q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= '0;
			center_y_q   <= '0;
			center_z_q   <= '0;
			radius_q     <= '0;
			max_lights_q <= 3'd4;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lst_pkg::CFG_CENTER_X:   center_x_q   <= cfg_data;
				lst_pkg::CFG_CENTER_Y:   center_y_q   <= cfg_data;
				lst_pkg::CFG_CENTER_Z:   center_z_q   <= cfg_data;
				lst_pkg::CFG_RADIUS:     radius_q     <= cfg_data[30:0];
				lst_pkg::CFG_MAX_LIGHTS: max_lights_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	lst_front #(.LIGHT_SLOTS(LIGHT_SLOTS), .IDX_W(IDX_W)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.light_type(light_type), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.light_range(light_range), .inv_range_sq(inv_range_sq),
		.intensity(intensity), .last_light(last_light),
		.q_full(q_full), .q_push(q_push), .q_data(q_wdata)
	);

	lst_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr(q_push), .wdata(q_wdata), .q_full(q_full),
		.rd(q_pop), .q_empty(q_empty), .rdata(q_rdata)
	);

	lst_back #(.MAX_OUT(MAX_OUT), .MAX_SCORED(MAX_SCORED), .IDX_W(IDX_W)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
		.center_x(center_x_q), .center_y(center_y_q), .center_z(center_z_q),
		.bound_radius(radius_q), .max_lights(max_lights_q),
		.empty(empty), .pop(pop), .light_index(light_index), .out_slot(out_slot),
		.none_selected(none_selected), .last_result(last_result)
	);

endmodule

### rtl/lst_queue.sv
// Two-word queue between the front and back parts.
// Payload is an opaque vector; depends on nothing.
module lst_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         q_full,
	input  logic         rd,
	output logic         q_empty,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !q_full) begin
				mem_q[wp_q] <= wdata;
				wp_q        <= ~wp_q;
			end
			if (rd && !q_empty)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr && !q_full) ? 1 : 0) - 2'((rd && !q_empty) ? 1 : 0);
		end
	end

endmodule

### rtl/lst_front.sv
// Front part: accepts lights, numbers them and classifies them.
// Depends on lst_pkg; pushes words into lst_queue.
module lst_front #(
	parameter int LIGHT_SLOTS = lst_pkg::LIGHT_SLOTS_DEF,
	parameter int IDX_W       = $clog2(LIGHT_SLOTS)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [1:0]                           light_type,
	input  logic signed [31:0]                   pos_x,
	input  logic signed [31:0]                   pos_y,
	input  logic signed [31:0]                   pos_z,
	input  logic signed [31:0]                   light_range,
	input  logic [31:0]                          inv_range_sq,
	input  logic [15:0]                          intensity,
	input  logic                                 last_light,
	input  logic                                 q_full,
	output logic                                 q_push,
	output logic [IDX_W+$bits(lst_pkg::item_t)-1:0] q_data
);

	localparam int PW = $clog2(LIGHT_SLOTS + 1);

	logic [PW-1:0]  pos_q;
	logic           in_range;
	lst_pkg::item_t item;

	assign full     = q_full;
	assign q_push   = push && !q_full;
	assign in_range = (pos_q < PW'(LIGHT_SLOTS));

	always_comb begin
		item.kind = lst_pkg::KIND_SKIP;
		if (in_range && light_type == lst_pkg::TYPE_DIRECTIONAL)
			item.kind = lst_pkg::KIND_DIR;
		else if (in_range && light_type == lst_pkg::TYPE_POINT)
			item.kind = lst_pkg::KIND_POINT;
		item.pos_x        = pos_x;
		item.pos_y        = pos_y;
		item.pos_z        = pos_z;
		item.light_range  = light_range;
		item.inv_range_sq = inv_range_sq;
		item.intensity    = intensity;
		item.last_light   = last_light;
	end

	assign q_data = {pos_q[IDX_W-1:0], item};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			if (last_light)
				pos_q <= '0;
			else if (in_range)
				pos_q <= pos_q + PW'(1);
		end
	end

endmodule

### rtl/lst_back.sv
// Back part: culls and scores point lights, keeps the lists, emits results.
// Depends on lst_pkg; reads words from lst_queue.
module lst_back #(
	parameter int MAX_OUT    = lst_pkg::MAX_OUT_DEF,
	parameter int MAX_SCORED = lst_pkg::MAX_SCORED_DEF,
	parameter int IDX_W      = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  logic [IDX_W+$bits(lst_pkg::item_t)-1:0] q_data,
	output logic                                 q_pop,
	input  logic signed [31:0]                   center_x,
	input  logic signed [31:0]                   center_y,
	input  logic signed [31:0]                   center_z,
	input  logic [30:0]                          bound_radius,
	input  logic [2:0]                           max_lights,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [7:0]                           light_index,
	output logic [1:0]                           out_slot,
	output logic                                 none_selected,
	output logic                                 last_result
);

	localparam int CNT_W = $clog2(MAX_OUT + 1);
	localparam int IW    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
	localparam int SC_W  = $clog2(MAX_SCORED + 1);
	localparam int IT_W  = $bits(lst_pkg::item_t);

	typedef enum logic [3:0] {
		ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_CMP, ST_D0, ST_D1,
		ST_X, ST_DIV, ST_SC, ST_INS, ST_EMIT
	} state_t;

	state_t             state_q;
	lst_pkg::item_t     hd;
	logic [IDX_W-1:0]   hd_idx;

	logic [31:0]        ax_q, ay_q, az_q, md_q, inv_q;
	logic               rpos_q;
	logic [15:0]        inten_q;
	logic [IDX_W-1:0]   idx_q;
	logic               last_q;
	logic [63:0]        prod_q;
	logic [65:0]        acc_q;
	logic [47:0]        dist_q;
	logic [55:0]        lo_q;
	logic [48:0]        den_q;
	logic [48:0]        rem_q;
	logic [16:0]        quo_q;
	logic [4:0]         dcnt_q;
	logic [16:0]        atten_q;

	logic [IDX_W-1:0]   dir_idx_q  [MAX_OUT];
	logic [IDX_W-1:0]   best_idx_q [MAX_OUT];
	logic [32:0]        best_sc_q  [MAX_OUT];
	logic [CNT_W-1:0]   dir_cnt_q;
	logic [CNT_W-1:0]   best_cnt_q;
	logic [SC_W-1:0]    scored_q;
	logic [CNT_W-1:0]   emit_q;

	logic               ov_q;
	logic [IDX_W-1:0]   o_idx_q;
	logic [1:0]         o_slot_q;
	logic               o_none_q;
	logic               o_last_q;

	logic [31:0]        mul_a, mul_b;
	logic [32:0]        dxs, dys, dzs;
	logic [31:0]        ax, ay, az;
	logic [CNT_W-1:0]   lim;
	logic [CNT_W:0]     total;
	logic [CNT_W:0]     sum;
	logic               emit_last;
	logic [IDX_W-1:0]   emit_idx;
	logic [CNT_W-1:0]   bsel;
	logic [CNT_W+1:0]   emit_ext;
	logic               load;
	logic [CNT_W-1:0]   ins_pos;
	logic [32:0]        score;
	logic [79:0]        xprod;
	logic [49:0]        dv_t;
	logic               dv_ge;
	logic [IDX_W+7:0]   idx_ext;
	state_t             after;

	assign hd     = q_data[IT_W-1:0];
	assign hd_idx = q_data[IDX_W+IT_W-1:IT_W];
	assign q_pop  = (state_q == ST_IDLE) && !q_empty;
	assign after  = last_q ? ST_EMIT : ST_IDLE;

	always_comb begin
		dxs = {hd.pos_x[31], hd.pos_x} - {center_x[31], center_x};
		dys = {hd.pos_y[31], hd.pos_y} - {center_y[31], center_y};
		dzs = {hd.pos_z[31], hd.pos_z} - {center_z[31], center_z};
		ax  = dxs[32] ? 32'(-dxs) : dxs[31:0];
		ay  = dys[32] ? 32'(-dys) : dys[31:0];
		az  = dzs[32] ? 32'(-dzs) : dzs[31:0];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_M0:   begin mul_a = ax_q; mul_b = ax_q; end
			ST_M1:   begin mul_a = ay_q; mul_b = ay_q; end
			ST_M2:   begin mul_a = az_q; mul_b = az_q; end
			ST_M3:   begin mul_a = md_q; mul_b = md_q; end
			ST_D0:   begin mul_a = {8'd0, dist_q[23:0]}; mul_b = inv_q; end
			ST_D1:   begin mul_a = {8'd0, dist_q[47:24]}; mul_b = inv_q; end
			ST_SC:   begin mul_a = {16'd0, inten_q}; mul_b = {15'd0, atten_q}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		xprod = (80'(prod_q) << 24) + 80'(lo_q);
		dv_t  = {rem_q, 1'b0};
		dv_ge = (dv_t >= {1'b0, den_q});
		score = prod_q[32:0];
	end

	always_comb begin
		ins_pos = CNT_W'(MAX_OUT);
		for (int k = MAX_OUT - 1; k >= 0; k--) begin
			if (!(CNT_W'(k) < best_cnt_q && best_sc_q[k] >= score))
				ins_pos = CNT_W'(k);
		end
	end

	always_comb begin
		lim       = (32'(max_lights) > 32'(MAX_OUT)) ? CNT_W'(MAX_OUT) : CNT_W'(max_lights);
		sum       = {1'b0, dir_cnt_q} + {1'b0, best_cnt_q};
		total     = (sum > {1'b0, lim}) ? {1'b0, lim} : sum;
		emit_last = ({1'b0, emit_q} + (CNT_W+1)'(1) == total);
		bsel      = emit_q - dir_cnt_q;
		emit_idx  = (emit_q < dir_cnt_q) ? dir_idx_q[emit_q[IW-1:0]] : best_idx_q[bsel[IW-1:0]];
		emit_ext  = {2'b00, emit_q};
		load      = (state_q == ST_EMIT) && (!ov_q || pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (load)
			ov_q <= 1'b1;
		else if (pop)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dir_cnt_q  <= '0;
			best_cnt_q <= '0;
			scored_q   <= '0;
			emit_q     <= '0;
		end else begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						ax_q    <= ax;
						ay_q    <= ay;
						az_q    <= az;
						md_q    <= hd.light_range + {1'b0, bound_radius};
						rpos_q  <= !hd.light_range[31] && (hd.light_range != '0);
						inv_q   <= hd.inv_range_sq;
						inten_q <= hd.intensity;
						idx_q   <= hd_idx;
						last_q  <= hd.last_light;
						emit_q  <= '0;
						if (hd.kind == lst_pkg::KIND_DIR && dir_cnt_q < lim) begin
							dir_idx_q[dir_cnt_q[IW-1:0]] <= hd_idx;
							dir_cnt_q <= dir_cnt_q + CNT_W'(1);
						end
						if (hd.kind == lst_pkg::KIND_POINT)
							state_q <= ST_M0;
						else if (hd.last_light)
							state_q <= ST_EMIT;
					end
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: begin
					acc_q   <= 66'(prod_q);
					state_q <= ST_M2;
				end
				ST_M2: begin
					acc_q   <= acc_q + 66'(prod_q);
					state_q <= ST_M3;
				end
				ST_M3: begin
					acc_q   <= acc_q + 66'(prod_q);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rpos_q && acc_q > 66'(prod_q)) begin
						state_q <= after;
					end else if (scored_q >= SC_W'(MAX_SCORED)) begin
						state_q <= after;
					end else begin
						scored_q <= scored_q + SC_W'(1);
						dist_q   <= (acc_q[65:64] != 2'b00) ? '1 : acc_q[63:16];
						atten_q  <= lst_pkg::ATTEN_ONE;
						state_q  <= rpos_q ? ST_D0 : ST_SC;
					end
				end
				ST_D0: state_q <= ST_D1;
				ST_D1: begin
					lo_q    <= prod_q[55:0];
					state_q <= ST_X;
				end
				ST_X: begin
					if (xprod > lst_pkg::ATTEN_LIMIT) begin
						atten_q <= '0;
						state_q <= ST_SC;
					end else begin
						den_q   <= lst_pkg::DEN_BASE + xprod[48:0];
						rem_q   <= lst_pkg::REM_INIT;
						quo_q   <= '0;
						dcnt_q  <= 5'd16;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= dv_ge ? 49'(dv_t - {1'b0, den_q}) : dv_t[48:0];
					quo_q  <= {quo_q[15:0], dv_ge};
					dcnt_q <= dcnt_q - 5'd1;
					if (dcnt_q == 5'd0) begin
						atten_q <= {quo_q[15:0], dv_ge};
						state_q <= ST_SC;
					end
				end
				ST_SC: state_q <= ST_INS;
				ST_INS: begin
					if (ins_pos < CNT_W'(MAX_OUT)) begin
						for (int k = MAX_OUT - 1; k >= 0; k--) begin
							if (CNT_W'(k) == ins_pos) begin
								best_idx_q[k] <= idx_q;
								best_sc_q[k]  <= score;
							end else if (k > 0 && CNT_W'(k) > ins_pos) begin
								best_idx_q[k] <= best_idx_q[k-1];
								best_sc_q[k]  <= best_sc_q[k-1];
							end
						end
						if (best_cnt_q < CNT_W'(MAX_OUT))
							best_cnt_q <= best_cnt_q + CNT_W'(1);
					end
					state_q <= after;
				end
				ST_EMIT: begin
					if (load) begin
						if (total == '0) begin
							o_idx_q  <= '0;
							o_slot_q <= 2'd0;
							o_none_q <= 1'b1;
							o_last_q <= 1'b1;
						end else begin
							o_idx_q  <= emit_idx;
							o_slot_q <= emit_ext[1:0];
							o_none_q <= 1'b0;
							o_last_q <= emit_last;
							emit_q   <= emit_q + CNT_W'(1);
						end
						if (total == '0 || emit_last) begin
							dir_cnt_q  <= '0;
							best_cnt_q <= '0;
							scored_q   <= '0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign idx_ext       = {8'd0, o_idx_q};
	assign empty         = !ov_q;
	assign light_index   = idx_ext[7:0];
	assign out_slot      = o_slot_q;
	assign none_selected = o_none_q;
	assign last_result   = o_last_q;

`ifndef SYNTHESIS
	a_best_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		best_cnt_q <= CNT_W'(MAX_OUT)) else $error("best list overfilled");
	a_scored: assert property (@(posedge clk) disable iff (!arst_n)
		scored_q <= SC_W'(MAX_SCORED)) else $error("scored count overran");
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && o_none_q |-> o_last_q) else $error("none result not final");
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |=> state_q == ST_DIV || state_q == ST_SC)
		else $error("divider left early");
`endif

endmodule

### test/tb.sv
// Self-checking testbench for light_select_top_k_core: queued light items and
// config writes, random idling on both sides, results checked against an inline model.
// Depends on lst_pkg and the RTL under rtl/.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]  ltype;
		logic [31:0] px, py, pz, rng, inv;
		logic [15:0] inten;
		logic        last;
	} light_t;

	typedef struct {
		logic [7:0] idx;
		logic [1:0] slot;
		logic       none;
		logic       last;
	} pick_t;

	localparam int WATCHDOG = 4000;
	localparam logic [79:0] SAT48 = 80'hFFFF_FFFF_FFFF;

	logic clk = 1'b0, arst_n = 1'b0;
	logic push = 1'b0, pop = 1'b0, cfg_valid = 1'b0;
	logic full, empty, cfg_ready;
	logic [1:0] light_type = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, light_range = '0;
	logic [31:0] inv_range_sq = '0, cfg_data = '0;
	logic [15:0] intensity = '0;
	logic last_light = 1'b0;
	logic [lst_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] light_index;
	logic [1:0] out_slot;
	logic none_selected, last_result;

	light_select_top_k_core u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model configuration and run state
	logic [31:0] m_cx = '0, m_cy = '0, m_cz = '0;
	logic [30:0] m_radius = '0;
	logic [2:0]  m_budget = 3'd4;
	int unsigned m_pos = 0, m_dir_cnt = 0, m_best_cnt = 0, m_scored = 0;
	logic [7:0]  m_dir_idx [4];
	logic [7:0]  m_best_idx [4];
	logic [32:0] m_best_score [4];

	light_t light_q [$];
	pick_t  pick_q [$];
	int errors = 0, n_lights = 0, n_picks = 0, n_cfg = 0, idle_cnt = 0;
	bit calm = 0;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, n_picks);
	endtask

	function automatic logic [33:0] absdiff(logic [31:0] a, logic [31:0] b);
		logic signed [33:0] d;
		d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
		return d < 0 ? -d : d;
	endfunction

	function automatic int unsigned eff_budget();
		return m_budget > 4 ? 4 : m_budget;
	endfunction

	task automatic rank_point(logic [7:0] idx, logic [32:0] score);
		int unsigned p, n;
		p = 0;
		n = m_best_cnt;
		while (p < n && m_best_score[p] >= score) p++;
		if (p >= 4) return;
		if (n >= 4) n = 3;
		for (int k = n; k > p; k--) begin
			m_best_idx[k] = m_best_idx[k-1];
			m_best_score[k] = m_best_score[k-1];
		end
		m_best_idx[p] = idx;
		m_best_score[p] = score;
		if (m_best_cnt < 4) m_best_cnt++;
	endtask

	task automatic score_point(logic [7:0] idx, light_t l);
		logic [67:0] s, m2, md;
		logic [33:0] a;
		logic [79:0] dsq, x;
		logic [16:0] att;
		s = 0;
		a = absdiff(l.px, m_cx); s += a * a;
		a = absdiff(l.py, m_cy); s += a * a;
		a = absdiff(l.pz, m_cz); s += a * a;
		if ($signed(l.rng) > 0) begin
			md = l.rng + m_radius;
			m2 = md * md;
			if (s > m2) return;
		end
		if (m_scored >= 32) return;
		m_scored++;
		dsq = s >> 16;
		if (dsq > SAT48) dsq = SAT48;
		att = lst_pkg::ATTEN_ONE;
		if ($signed(l.rng) > 0) begin
			x = dsq * l.inv;
			att = (x > lst_pkg::ATTEN_LIMIT) ? 17'd0 :
				17'((80'h1 << 48) / ((80'h1 << 32) + x));
		end
		rank_point(idx, l.inten * att);
	endtask

	task automatic absorb_light(light_t l);
		int unsigned lim, sent;
		pick_t p;
		if (m_pos < 256) begin
			if (l.ltype == lst_pkg::TYPE_DIRECTIONAL) begin
				if (m_dir_cnt < eff_budget()) begin
					m_dir_idx[m_dir_cnt] = m_pos[7:0];
					m_dir_cnt++;
				end
			end else if (l.ltype == lst_pkg::TYPE_POINT) begin
				score_point(m_pos[7:0], l);
			end
			m_pos++;
		end
		if (!l.last) return;
		lim = eff_budget();
		sent = 0;
		for (int k = 0; k < m_dir_cnt && sent < lim; k++, sent++)
			pick_q.push_back('{m_dir_idx[k], sent[1:0], 1'b0, 1'b0});
		for (int k = 0; k < m_best_cnt && sent < lim; k++, sent++)
			pick_q.push_back('{m_best_idx[k], sent[1:0], 1'b0, 1'b0});
		if (sent == 0) begin
			pick_q.push_back('{8'd0, 2'd0, 1'b1, 1'b1});
		end else begin
			p = pick_q.pop_back();
			p.last = 1'b1;
			pick_q.push_back(p);
		end
		m_pos = 0; m_dir_cnt = 0; m_best_cnt = 0; m_scored = 0;
	endtask

	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	int push_gap = 0;
	always @(posedge clk) begin
		light_t l;
		bit drive;
		if (arst_n) begin
			if (push && !full) begin
				absorb_light(light_q.pop_front());
				n_lights++;
				push_gap = gap_len();
			end
			drive = 0;
			if (push_gap > 0) push_gap--;
			else if (light_q.size() > 0) drive = 1;
			if (drive) begin
				l = light_q[0];
				light_type <= l.ltype; pos_x <= l.px; pos_y <= l.py; pos_z <= l.pz;
				light_range <= l.rng; inv_range_sq <= l.inv; intensity <= l.inten;
				last_light <= l.last;
			end
			push <= drive;
		end
	end

	int pop_gap = 0;
	always @(posedge clk) begin
		pick_t w;
		if (arst_n) begin
			if (pop && !empty) begin
				n_picks++;
				if (pick_q.size() == 0) begin
					errors++;
					$display("unexpected result word idx %0h", light_index);
				end else begin
					w = pick_q.pop_front();
					if (none_selected !== w.none) report("none_selected", none_selected, w.none);
					if (last_result !== w.last) report("last_result", last_result, w.last);
					if (out_slot !== w.slot) report("out_slot", out_slot, w.slot);
					if (light_index !== w.idx) report("light_index", light_index, w.idx);
				end
				pop_gap = gap_len();
			end
			if (pop_gap > 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("watchdog expired, %0d results outstanding", pick_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic drain();
		while (light_q.size() > 0 || push || pick_q.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [lst_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_cfg++;
		case (idx)
			lst_pkg::CFG_CENTER_X:   m_cx = val;
			lst_pkg::CFG_CENTER_Y:   m_cy = val;
			lst_pkg::CFG_CENTER_Z:   m_cz = val;
			lst_pkg::CFG_RADIUS:     m_radius = val[30:0];
			lst_pkg::CFG_MAX_LIGHTS: m_budget = val[2:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rnd_span();
		logic [31:0] v;
		v = $urandom() >> $urandom_range(31);
		return $urandom_range(1) ? -v : v;
	endfunction

	function automatic light_t rnd_light(bit last);
		light_t l;
		int r;
		r = $urandom_range(99);
		l.ltype = r < 30 ? lst_pkg::TYPE_DIRECTIONAL : r < 85 ? lst_pkg::TYPE_POINT :
			2'($urandom_range(3, 2));
		if ($urandom_range(1)) begin
			l.px = m_cx + rnd_span(); l.py = m_cy + rnd_span(); l.pz = m_cz + rnd_span();
		end else begin
			l.px = $urandom(); l.py = $urandom(); l.pz = $urandom();
		end
		r = $urandom_range(9);
		l.rng = r < 2 ? -($urandom() >> $urandom_range(31)) : r < 3 ? 0 :
			$urandom() >> $urandom_range(31, 1);
		l.inv = $urandom_range(1) ? $urandom() : $urandom() >> $urandom_range(31);
		l.inten = 16'($urandom());
		l.last = last;
		return l;
	endfunction

	task automatic queue_set(int len);
		for (int i = 0; i < len; i++) light_q.push_back(rnd_light(i == len - 1));
	endtask

	function automatic light_t pt(logic [31:0] x, logic [31:0] rng, logic [15:0] inten,
			logic [1:0] t, bit last);
		return '{t, x, 32'd0, 32'd0, rng, 32'h0001_0000, inten, last};
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: budget overflow, cull boundary, range kinds, ignored types
		for (int i = 0; i < 5; i++) light_q.push_back(pt(0, 0, 0, lst_pkg::TYPE_DIRECTIONAL, 0));
		light_q.push_back(pt(32'h0001_0000, 32'h0001_0000, 16'hFFFF, lst_pkg::TYPE_POINT, 1));
		light_q.push_back(pt(32'h0001_0000, 32'h0001_0000, 16'h0100, lst_pkg::TYPE_POINT, 0));
		light_q.push_back(pt(32'h0001_0001, 32'h0001_0000, 16'hFFFF, lst_pkg::TYPE_POINT, 0));
		light_q.push_back(pt(32'h8000_0000, 32'h0000_0000, 16'h0000, lst_pkg::TYPE_POINT, 0));
		light_q.push_back(pt(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, lst_pkg::TYPE_POINT, 0));
		light_q.push_back(pt(32'h0000_4000, 32'h7FFF_FFFF, 16'hFFFF, lst_pkg::TYPE_POINT, 0));
		light_q.push_back(pt(0, 0, 16'hFFFF, 2'd2, 0));
		light_q.push_back(pt(0, 0, 16'hFFFF, 2'd3, 0));
		light_q.push_back('{lst_pkg::TYPE_POINT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1});
		light_q.push_back(pt(0, 0, 0, 2'd2, 1));
		light_q.push_back(pt(0, 0, 16'h0010, lst_pkg::TYPE_DIRECTIONAL, 0));
		light_q.push_back(pt(0, 0, 16'h0010, lst_pkg::TYPE_POINT, 0));
		drain();
		// budget changed in the middle of a set
		write_reg(lst_pkg::CFG_MAX_LIGHTS, 32'd1);
		light_q.push_back(pt(0, 0, 0, lst_pkg::TYPE_DIRECTIONAL, 0));
		light_q.push_back(pt(0, 0, 16'h0020, lst_pkg::TYPE_POINT, 1));
		drain();
		write_reg(lst_pkg::CFG_MAX_LIGHTS, 32'd0);
		light_q.push_back(pt(0, 0, 16'h0020, lst_pkg::TYPE_POINT, 1));
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 3);
			case (ph)
				0: begin
					write_reg(lst_pkg::CFG_CENTER_X, 32'h8000_0000);
					write_reg(lst_pkg::CFG_CENTER_Y, 32'h7FFF_FFFF);
					write_reg(lst_pkg::CFG_CENTER_Z, 32'hFFFF_FFFF);
					write_reg(lst_pkg::CFG_RADIUS, 32'h7FFF_FFFF);
					write_reg(lst_pkg::CFG_MAX_LIGHTS, 32'd7);
				end
				1: begin
					write_reg(lst_pkg::CFG_CENTER_X, 32'd0); write_reg(lst_pkg::CFG_CENTER_Y, 32'd0);
					write_reg(lst_pkg::CFG_CENTER_Z, 32'd0); write_reg(lst_pkg::CFG_RADIUS, 32'd0);
					write_reg(lst_pkg::CFG_MAX_LIGHTS, 32'd4);
				end
				default: begin
					write_reg(lst_pkg::CFG_CENTER_X, rnd_span());
					write_reg(lst_pkg::CFG_CENTER_Y, rnd_span());
					write_reg(lst_pkg::CFG_CENTER_Z, rnd_span());
					write_reg(lst_pkg::CFG_RADIUS, $urandom());
					write_reg(lst_pkg::CFG_MAX_LIGHTS, $urandom_range(7));
				end
			endcase
			if (ph == 5) begin
				// too many lights for the position counter
				for (int i = 0; i < 258; i++)
					light_q.push_back(pt(0, 0, 16'h0001,
						i % 7 == 0 ? lst_pkg::TYPE_DIRECTIONAL : 2'd2, i == 257));
			end else if (ph == 6) begin
				// more survivors than can be scored
				for (int i = 0; i < 36; i++)
					light_q.push_back('{lst_pkg::TYPE_POINT, 32'(i), 32'd0, 32'd0, 32'd0, 32'd0,
						16'($urandom_range(3) + i), i == 35});
			end
			for (int n = 0; n < 3; ) begin
				int len;
				len = $urandom_range(9) == 0 ? $urandom_range(1) : $urandom_range(10, 2);
				if (len == 0) len = 1;
				queue_set(len);
				n += len;
			end
			drain();
		end
		$display("%0d lights in, %0d result words checked, %0d register writes,",
			n_lights, n_picks, n_cfg);
		$display("covering budget 0..7, extreme centers and radius, long and overfull sets");
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

### light_select_top_k_core.f
rtl/lst_pkg.sv
rtl/lst_queue.sv
rtl/lst_front.sv
rtl/lst_back.sv
rtl/light_select_top_k_core.sv
test/tb.sv
